>>> rtl/core/isq_pkg.sv
// shared constants, codes and types for the indexed sequence store
package isq_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned LEN_W   = 7;

	// wide enough for any slot or length up to the largest supported capacity
	localparam int unsigned SLOT_W = 13;

	localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// broadcast to every cell of the row
	typedef struct packed {
		logic [1:0]                op;
		logic [SLOT_W-1:0]         slot;
		logic signed [VALUE_W-1:0] value;
	} ctrl_t;

endpackage

>>> rtl/core/isq_ifs.sv
// command and response channel interfaces
interface isq_cmd_if import isq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] item_value;

	modport source (output valid, command, position, item_value, input ready);
	modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface isq_rsp_if import isq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic [STAT_W-1:0]         status;
	logic [LEN_W-1:0]          length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink   (input valid, read_value, status, length, output ready);
endinterface

>>> rtl/core/isq_cell.sv
// one storage cell of the row: holds one entry, shifts with its neighbours
module isq_cell import isq_pkg::*; #(
	parameter int unsigned INDEX = 0
) (
	input  logic                      clk,
	input  ctrl_t                     ctrl,
	input  logic signed [VALUE_W-1:0] prev_value,
	input  logic signed [VALUE_W-1:0] next_value,
	output logic signed [VALUE_W-1:0] value,
	output logic signed [VALUE_W-1:0] read_data
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

	logic signed [VALUE_W-1:0] value_q;
	logic                      at_slot;
	logic                      past_slot;

	assign at_slot   = ctrl.slot == MY_SLOT;
	assign past_slot = MY_SLOT > ctrl.slot;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_INSERT: begin
				if (past_slot) begin
					value_q <= prev_value;
				end else if (at_slot) begin
					value_q <= ctrl.value;
				end
			end
			OP_DELETE: begin
				if (at_slot || past_slot) begin
					value_q <= next_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign value     = value_q;
	assign read_data = at_slot ? value_q : '0;

endmodule

>>> rtl/core/indexed_sequence_store.sv
// indexed sequence store top level: command decode, length and response register
//
// an ordered list of up to CAPACITY signed 32-bit entries kept in a row of cells
// cmd channel (valid/ready): one word holds command, position and item_value
//   read, insert at head, insert at tail, insert before position, delete
// rsp channel (valid/ready): one word per command with read_value, status
//   (done, position out of range, store full) and the length after the command
// the response word is registered and presented in the cycle after the command is taken
// throughput: one command per cycle; every cell shifts in the same cycle as the
//   decode, so a command only ever waits for a free response register
// the response register decouples the two sides: while it holds an untaken word
//   and rsp.ready is low, cmd.ready is low and the store holds still
// reset clears the length and the response valid; the entries themselves are not
//   cleared and are only ever read below the length, so no clearing pass is needed
// CAPACITY may range from 1 to 4096; length is reported modulo 128
module indexed_sequence_store_top import isq_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	isq_cmd_if.sink        cmd,
	isq_rsp_if.source      rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// length and response register
	logic [CNT_W-1:0]          count_q;
	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] read_value_q;
	logic [STAT_W-1:0]         status_q;
	logic [LEN_W-1:0]          length_q;

	logic                      cmd_fire;
	logic [SLOT_W-1:0]         pos_w;
	logic [SLOT_W-1:0]         cnt_w;
	logic                      full;
	ctrl_t                     ctrl;
	logic [STAT_W-1:0]         status_d;
	logic [CNT_W-1:0]          count_d;
	logic                      read_ok;
	logic signed [VALUE_W-1:0] read_any;

	logic signed [VALUE_W-1:0] cell_value [CAPACITY];
	logic signed [VALUE_W-1:0] cell_read  [CAPACITY];

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign pos_w = SLOT_W'(cmd.position);
	assign cnt_w = SLOT_W'(count_q);
	assign full  = count_q == CAP_CNT;

	// decode: pick the cell operation, the slot it acts on and the status
	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.slot  = pos_w;
		ctrl.value = cmd.item_value;
		status_d   = ST_DONE;
		count_d    = count_q;
		read_ok    = 1'b0;
		unique case (cmd.command)
			CMD_READ: begin
				if (pos_w < cnt_w) begin
					read_ok = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			CMD_INS_HEAD: begin
				ctrl.slot = '0;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_INS_TAIL: begin
				ctrl.slot = cnt_w;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_INS_AT: begin
				// range check takes priority over the full check
				if (pos_w > cnt_w) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos_w < cnt_w) begin
					ctrl.op = OP_DELETE;
					count_d = count_q - 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				// unused codes: no change, done
			end
		endcase
		if (!cmd_fire) begin
			ctrl.op = OP_HOLD;
		end
	end

	// the row of cells; each hands its entry to both neighbours every cycle
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_v;
		logic signed [VALUE_W-1:0] next_v;

		if (k == 0) begin : g_first
			assign prev_v = cmd.item_value;
		end else begin : g_mid_prev
			assign prev_v = cell_value[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign next_v = cell_value[k];
		end else begin : g_mid_next
			assign next_v = cell_value[k+1];
		end

		isq_cell #(
			.INDEX (k)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.prev_value (prev_v),
			.next_value (next_v),
			.value      (cell_value[k]),
			.read_data  (cell_read[k])
		);
	end

	// only the addressed cell drives a non-zero read word
	always_comb begin
		read_any = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			read_any = read_any | cell_read[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			read_value_q <= read_ok ? read_any : '0;
			status_q     <= status_d;
			length_q     <= LEN_W'(count_d);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;

	// length never runs past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("length above capacity");

	// a full report only ever comes from a full store
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && status_q == ST_FULL |-> full)
		else $error("full status from a store with free room");

	// a rejected command leaves the length alone
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && status_d != ST_DONE |=> count_q == $past(count_q))
		else $error("rejected command changed the length");

	// a successful delete shortens the store by exactly one
	a_delete_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd.command == CMD_DELETE && status_d == ST_DONE
		|=> count_q == $past(count_q) - 1'b1)
		else $error("delete did not shorten the store by one");

	// every taken command leaves a response word behind
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> rsp_valid_q)
		else $error("command taken without a response word");

endmodule

>>> tb/isq_store_checker.sv
// response checker for the indexed sequence store: predicts each reply and compares
module isq_store_checker import isq_pkg::*; #(
	parameter int unsigned DEPTH = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	isq_cmd_if          cmd_mon,
	isq_rsp_if          rsp_mon,
	output int unsigned stored_now,
	output int unsigned owed_now,
	output int unsigned errors
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [STAT_W-1:0]         status;
		logic [LEN_W-1:0]          length;
	} rsp_word_t;

	logic signed [VALUE_W-1:0] rows [DEPTH];
	int unsigned               stored;
	rsp_word_t                 owed_replies [$];
	rsp_word_t                 want;

	initial errors = 0;

	// applies one command to the shadow list and returns the reply it should give
	function automatic rsp_word_t apply_command(input logic [CMD_W-1:0] c,
			input logic [POS_W-1:0] p, input logic signed [VALUE_W-1:0] v);
		rsp_word_t   w;
		int unsigned slot;
		w.read_value = '0;
		w.status     = ST_DONE;
		slot         = stored;
		case (c)
			CMD_READ: begin
				if (p < stored)
					w.read_value = rows[p];
				else
					w.status = ST_RANGE;
			end
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				if (c == CMD_INS_HEAD)
					slot = 0;
				else if (c == CMD_INS_AT)
					slot = 32'(p);
				// range is judged before fullness
				if (slot > stored)
					w.status = ST_RANGE;
				else if (stored >= DEPTH)
					w.status = ST_FULL;
				else begin
					for (int unsigned k = stored; k > slot; k--)
						rows[k] = rows[k-1];
					rows[slot] = v;
					stored++;
				end
			end
			CMD_DELETE: begin
				if (p < stored) begin
					for (int unsigned k = 32'(p); k + 1 < stored; k++)
						rows[k] = rows[k+1];
					stored--;
				end else
					w.status = ST_RANGE;
			end
			default: ;
		endcase
		w.length = stored[LEN_W-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored = 0;
			owed_replies.delete();
			stored_now <= 0;
			owed_now   <= 0;
		end else begin
			if (cmd_mon.valid && cmd_mon.ready)
				owed_replies.push_back(apply_command(cmd_mon.command, cmd_mon.position,
					cmd_mon.item_value));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (owed_replies.size() == 0) begin
					$error("response word with nothing owed: read_value %0d status %0d length %0d",
						rsp_mon.read_value, rsp_mon.status, rsp_mon.length);
					errors++;
				end else begin
					want = owed_replies.pop_front();
					if (rsp_mon.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, rsp_mon.read_value);
						errors++;
					end
					if (rsp_mon.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_mon.status);
						errors++;
					end
					if (rsp_mon.length !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, rsp_mon.length);
						errors++;
					end
				end
			end
			stored_now <= stored;
			owed_now   <= owed_replies.size();
		end
	end

endmodule

>>> tb/testbench.sv
// top of the indexed sequence store testbench: clock, reset, stimulus and verdict
module testbench;
	import isq_pkg::*;

	localparam int unsigned STORE_DEPTH = CAPACITY_DEF;
	localparam int unsigned WORDS_PER_MODE = 150;
	localparam int unsigned LONG_HOLD = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	isq_cmd_if cmd_ch ();
	isq_rsp_if rsp_ch ();

	int unsigned stored_now;
	int unsigned owed_now;
	int unsigned err_count;

	// idle chances in percent; the sender's is only used by the stimulus process
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	// each bump asks the receiver for one long hold-off
	int unsigned hold_asks;

	always #10 clk = ~clk;

	indexed_sequence_store_top #(.CAPACITY(STORE_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	isq_store_checker #(.DEPTH(STORE_DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_mon    (cmd_ch),
		.rsp_mon    (rsp_ch),
		.stored_now (stored_now),
		.owed_now   (owed_now),
		.errors     (err_count)
	);

	// offers one word after a random idle gap and waits for it to be taken
	task automatic send_word(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
			input logic signed [VALUE_W-1:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= c;
		cmd_ch.position   <= p;
		cmd_ch.item_value <= v;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	// sender stays quiet until every owed reply has come back
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_now != 0);
	endtask

	// receiver: random stalls, plus a long counted hold-off whenever one is asked for
	initial begin : rsp_side
		int unsigned quiet;
		int unsigned seen;
		quiet = 0;
		seen  = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != seen) begin
				seen  = hold_asks;
				quiet = LONG_HOLD;
			end
			if (quiet > 0) begin
				quiet--;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin : stimulus
		logic [CMD_W-1:0]          c;
		logic [POS_W-1:0]          p;
		logic signed [VALUE_W-1:0] v;
		int unsigned               len;
		int unsigned               r;
		int unsigned               full_hits;
		bit                        draining;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.command    <= CMD_READ;
		cmd_ch.position   <= '0;
		cmd_ch.item_value <= '0;
		arst_n            <= 1'b0;
		hold_asks         <= 0;
		rx_idle_pct       <= 54;
		tx_idle_pct       = 23;
		draining          = 1'b0;
		full_hits         = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store first, every reject that needs no data
		send_word(CMD_READ, 8'd0, 32'sd0);
		send_word(CMD_DELETE, 8'd0, 32'sd0);
		send_word(CMD_INS_AT, 8'd1, 32'sd7);
		// positional insert at zero into an empty store, then head, tail, append and two more positional inserts
		send_word(CMD_INS_AT, 8'd0, 32'sh7FFF_FFFF);
		send_word(CMD_INS_HEAD, 8'd0, 32'sh8000_0000);
		send_word(CMD_INS_TAIL, 8'd0, 32'sd0);
		send_word(CMD_INS_AT, 8'd3, -32'sd1);
		send_word(CMD_INS_AT, 8'd2, 32'sh5A5A_A5A5);
		send_word(CMD_INS_AT, 8'd0, 32'sh1234_5678);
		// list now holds six words; read head, middle, tail, then read and insert past the end
		send_word(CMD_READ, 8'd0, 32'sd0);
		send_word(CMD_READ, 8'd3, 32'sd0);
		send_word(CMD_READ, 8'd5, 32'sd0);
		send_word(CMD_READ, 8'd6, 32'sd0);
		send_word(CMD_READ, 8'd255, -32'sd1);
		send_word(CMD_INS_AT, 8'd255, -32'sd1);
		send_word(CMD_INS_AT, 8'd7, 32'sd1);
		// deletes: tail, head, middle, out of range
		send_word(CMD_DELETE, 8'd5, 32'sd0);
		send_word(CMD_DELETE, 8'd0, 32'sd0);
		send_word(CMD_DELETE, 8'd1, 32'sd0);
		send_word(CMD_DELETE, 8'd255, 32'sd0);
		// spare command codes do nothing
		for (int k = int'(CMD_DELETE) + 1; k < (1 << CMD_W); k++)
			send_word(k[CMD_W-1:0], 8'd255, -32'sd1);
		send_word(CMD_READ, 8'd0, 32'sd0);
		wait_drained();

		// random part: the list tides between filling up to full and draining to empty
		for (int unsigned mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle_pct = 23;
					rx_idle_pct <= 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct <= 23;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			for (int unsigned n = 0; n < WORDS_PER_MODE; n++) begin
				// long receiver hold-off while the sender keeps offering
				if (n == 20 && mode != 1)
					hold_asks <= hold_asks + 1;
				len = stored_now;
				if (!draining && len >= STORE_DEPTH) begin
					full_hits++;
					if (full_hits > 12) begin
						draining  = 1'b1;
						full_hits = 0;
					end
				end else if (draining && len == 0)
					draining = 1'b0;

				// payload: mostly random, sometimes an extreme
				r = $urandom_range(99);
				if (r < 4)
					v = 32'sh8000_0000;
				else if (r < 8)
					v = 32'sh7FFF_FFFF;
				else if (r < 10)
					v = -32'sd1;
				else if (r < 12)
					v = 32'sd0;
				else
					v = $urandom();

				r = $urandom_range(99);
				if (r < 8) begin
					// noise: any code, any position
					c = CMD_W'($urandom_range((1 << CMD_W) - 1));
					p = POS_W'($urandom_range(255));
				end else begin
					if (!draining) begin
						if (r < 30)
							c = CMD_INS_HEAD;
						else if (r < 50)
							c = CMD_INS_TAIL;
						else if (r < 80)
							c = CMD_INS_AT;
						else if (r < 90)
							c = CMD_READ;
						else
							c = CMD_DELETE;
					end else begin
						if (r < 70)
							c = CMD_DELETE;
						else if (r < 80)
							c = CMD_READ;
						else if (r < 90)
							c = CMD_INS_AT;
						else if (r < 95)
							c = CMD_INS_HEAD;
						else
							c = CMD_INS_TAIL;
					end
					// positions mostly valid, now and then just past the edge
					if (c == CMD_INS_AT)
						p = POS_W'(($urandom_range(9) == 0) ? len + 1 : $urandom_range(len));
					else if (len == 0 || $urandom_range(9) == 0)
						p = POS_W'(len);
					else
						p = POS_W'($urandom_range(len - 1));
				end
				send_word(c, p, v);
			end
			// sender pause until every owed reply is back
			wait_drained();
		end

		// let any stray reply show up before the verdict
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// hard limit on the run, far beyond the slowest correct one
	initial begin : watchdog
		#4000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/isq_pkg.sv
rtl/core/isq_ifs.sv
rtl/core/isq_cell.sv
rtl/core/indexed_sequence_store.sv
tb/isq_store_checker.sv
tb/testbench.sv
